[hw/rtl/pkht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_pkg
// shared types, constants and hash helper for the pair key hash table
// ----------------------------------------------------------------------------
package pkht_pkg;

    localparam int          PKHT_DEPTH_DEFAULT = 256;
    localparam int          CFG_CAP_W          = 9;
    localparam int          CFG_CAP_RESET      = 256;
    localparam int          KEY_W              = 32;
    localparam int          VAL_W              = 8;
    localparam int          HASH_W             = 32;
    localparam int          MOD_BITS           = 4;
    localparam int          MOD_STEPS          = HASH_W / MOD_BITS;
    localparam int          MOD_CNT_W          = $clog2(MOD_STEPS);
    localparam logic [31:0] FNV_BASIS          = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME          = 32'd16777619;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_MOD,
        ST_ADDR,
        ST_READ,
        ST_CMP,
        ST_RESP
    } pkht_state_t;

    typedef struct packed {
        logic               occupied;
        logic [VAL_W-1:0]   value;
        logic [KEY_W-1:0]   ent;
        logic [KEY_W-1:0]   pkg;
    } slot_t;

    typedef struct packed {
        logic load_in;
        logic hash1;
        logic hash2;
        logic mod_step;
        logic probe_init;
        logic probe_next;
        logic slot_write;
        logic clear_step;
        logic res_capture;
        logic res_found;
        logic res_full;
        logic res_hit_value;
        logic res_load;
    } pkht_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cap_zero;
        logic mod_last;
        logic is_insert;
        logic slot_empty;
        logic key_match;
        logic walk_last;
        logic out_free;
    } pkht_status_t;

    // one fnv-1a word fold, low 32 bits of the product
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                  input logic [KEY_W-1:0]  w);
        logic [HASH_W-1:0] x;
        x = h ^ w;
        return x * FNV_PRIME;
    endfunction

endpackage

[hw/rtl/pkht_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pkht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/pkht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_ctrl
// sequencer for clear, hash, modulo, probe walk and result handoff
// ----------------------------------------------------------------------------
module pkht_ctrl
    import pkht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  pkht_status_t status,
    output pkht_cmd_t    cmd
);

    pkht_state_t state_reg;
    pkht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_HASH1;
                end
            end
            ST_HASH1:
            begin
                state_next = status.cap_zero ? ST_RESP : ST_HASH2;
            end
            ST_HASH2: state_next = ST_MOD;
            ST_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (status.slot_empty || status.key_match || status.walk_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_HASH1:
            begin
                cmd.hash1 = 1'b1;
                if (status.cap_zero)
                begin
                    cmd.res_capture = 1'b1;
                    cmd.res_full    = status.is_insert;
                end
            end
            ST_HASH2: cmd.hash2 = 1'b1;
            ST_MOD:   cmd.mod_step = 1'b1;
            ST_ADDR:  cmd.probe_init = 1'b1;
            ST_READ:  ;
            ST_CMP:
            begin
                priority if (status.slot_empty)
                begin
                    cmd.slot_write  = status.is_insert;
                    cmd.res_capture = 1'b1;
                end
                else if (status.key_match)
                begin
                    cmd.slot_write    = status.is_insert;
                    cmd.res_capture   = 1'b1;
                    cmd.res_found     = 1'b1;
                    cmd.res_hit_value = !status.is_insert;
                end
                else if (status.walk_last)
                begin
                    cmd.res_capture = 1'b1;
                    cmd.res_full    = status.is_insert;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            ST_RESP:  cmd.res_load = status.out_free;
            default:  ;
        endcase
    end

endmodule

[hw/rtl/pkht_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkht_dp
// datapath: capacity register, fnv-1a hash, radix-16 modulo, probe pointer,
// slot ram and output register
// ----------------------------------------------------------------------------
module pkht_dp
    import pkht_pkg::*;
#(
    parameter int TABLE_DEPTH = PKHT_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_CAP_W-1:0]  cfg_wr_data,
    input  logic [71:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    input  pkht_cmd_t             cmd,
    output pkht_status_t          status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CAP_W = IDX_W + 1;
    localparam int CAP_RESET_V = (TABLE_DEPTH < CFG_CAP_RESET) ? TABLE_DEPTH : CFG_CAP_RESET;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_V);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_DEPTH - 1);

    logic [CAP_W-1:0]     cap_reg;
    logic                 op_reg;
    logic [KEY_W-1:0]     pkg_reg;
    logic [KEY_W-1:0]     ent_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [CAP_W-1:0]     rem_reg;
    logic [CAP_W-1:0]     rem_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [CAP_W-1:0]     pos_inc;
    logic [CAP_W-1:0]     walk_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic                 res_found_reg;
    logic                 res_full_reg;
    logic [VAL_W-1:0]     res_value_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic                 out_full_reg;
    logic [VAL_W-1:0]     out_value_reg;
    logic [CAP_W-1:0]     cap_wr;
    slot_t                rd_slot;
    slot_t                new_slot;
    slot_t                wr_slot;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;

    // capacity clamped to the built depth on write
    assign cap_wr = (32'(cfg_wr_data) > 32'(TABLE_DEPTH)) ? CAP_MAX : CAP_W'(cfg_wr_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cap_wr;
        end
    end

    // remainder, four dividend bits per step
    always_comb
    begin
        logic [CAP_W:0]    r;
        logic [HASH_W-1:0] q;
        r = {1'b0, rem_reg};
        q = hash_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            r = {r[CAP_W-1:0], q[HASH_W-1]};
            q = q << 1;
            if (r >= {1'b0, cap_reg})
            begin
                r = r - {1'b0, cap_reg};
            end
        end
        rem_next = r[CAP_W-1:0];
    end

    assign pos_inc = CAP_W'({1'b0, pos_reg} + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= s_tuser[0];
            pkg_reg <= s_tdata[31:0];
            ent_reg <= s_tdata[63:32];
            val_reg <= s_tdata[71:64];
        end
        if (cmd.hash1)
        begin
            hash_reg <= fnv_fold(FNV_BASIS, pkg_reg);
        end
        else if (cmd.hash2)
        begin
            hash_reg <= fnv_fold(hash_reg, ent_reg);
        end
        else if (cmd.mod_step)
        begin
            hash_reg <= hash_reg << MOD_BITS;
        end
        if (cmd.hash2)
        begin
            rem_reg     <= '0;
            mod_cnt_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg     <= rem_next;
            mod_cnt_reg <= mod_cnt_reg + 1'b1;
        end
        if (cmd.probe_init)
        begin
            pos_reg  <= rem_reg[IDX_W-1:0];
            walk_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            pos_reg  <= (pos_inc == cap_reg) ? '0 : pos_inc[IDX_W-1:0];
            walk_reg <= walk_reg + 1'b1;
        end
        if (cmd.res_capture)
        begin
            res_found_reg <= cmd.res_found;
            res_full_reg  <= cmd.res_full;
            res_value_reg <= cmd.res_hit_value ? rd_slot.value : '0;
        end
        if (cmd.res_load)
        begin
            out_found_reg <= res_found_reg;
            out_full_reg  <= res_full_reg;
            out_value_reg <= res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign new_slot  = '{occupied: 1'b1, value: val_reg, ent: ent_reg, pkg: pkg_reg};
    assign wr_slot   = cmd.clear_step ? '0 : new_slot;
    assign ram_we    = cmd.clear_step || cmd.slot_write;
    assign ram_waddr = cmd.clear_step ? clr_reg : pos_reg;

    pkht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_slot),
        .raddr (pos_reg),
        .rdata (rd_slot)
    );

    assign status.clear_last = (clr_reg == IDX_LAST);
    assign status.cap_zero   = (cap_reg == '0);
    assign status.mod_last   = (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
    assign status.is_insert  = op_reg;
    assign status.slot_empty = !rd_slot.occupied;
    assign status.key_match  = (rd_slot.pkg == pkg_reg) && (rd_slot.ent == ent_reg);
    assign status.walk_last  = (CAP_W'(walk_reg + 1'b1) == cap_reg);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_full_reg, out_found_reg};

endmodule

[hw/rtl/pair_key_hash_index_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_key_hash_index_table_core
// open-addressed hash map from (package, entry) key pairs to 8-bit values
// ----------------------------------------------------------------------------
// usage
//   input stream: s_tuser selects lookup (0) or insert/update (1), s_tdata
//   carries the key pair and the value to store. one transfer is taken at a
//   time; s_tready is high only while the core waits for a new item.
//   output stream: one transfer per item with found, table_full and the value
//   of a lookup hit, held in an output register until m_tready takes it.
//   the core may accept the next item while that result still waits.
//   processing: the package key and then the entry key are folded into an
//   fnv-1a hash, the 8-digit radix-16 remainder of that hash by the capacity
//   picks the first slot, and the walk then probes slot by slot, each probe
//   one read of the single slot ram. capacity zero answers without a walk.
//   a new item is taken only once the result of the last one has moved into
//   the output register.
//   reset: after rst_n rises the slot ram is swept clear, every slot emptied;
//   s_tready stays low until the sweep ends. capacity resets to 256,
//   clamped to TABLE_DEPTH. write capacity only while no item is in flight.
//   a stalled receiver holds the result; a second result then waits inside.
// ----------------------------------------------------------------------------
module pair_key_hash_index_table_core
    import pkht_pkg::*;
#(
    parameter int TABLE_DEPTH = PKHT_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_CAP_W-1:0] cfg_wr_data,  // table_capacity
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,      // package_key, entry_key, store_value
    input  logic [0:0]           s_tuser,      // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,      // found_value
    output logic [1:0]           m_tuser       // found, table_full
);

    pkht_cmd_t    cmd;
    pkht_status_t status;

    pkht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pkht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !s_tready)
        else $error("input accepted during clear sweep");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and table_full both set");

endmodule
